/* hdl/mu8_pkg.sv */
// Shared types and constants for the modified UTF-8 to UTF-8 converter.
// No dependencies; used by every module under hdl/.
package mu8_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [5:0]  HIGH_TAG   = 6'b110110;
    localparam logic [5:0]  LOW_TAG    = 6'b110111;
    localparam logic [20:0] PLANE_BASE = 21'h10000;

    localparam logic [1:0] LEN_IDLE = 2'd0;
    localparam logic [1:0] LEN_TWO  = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // One record per input byte that produces output or ends a string: up to four bytes.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [1:0]      cnt_m1;
        logic            has_byte;
        logic            fin;
    } rec_t;

endpackage

/* hdl/modified_utf8_to_utf8.sv */
// Modified UTF-8 to standard UTF-8 stream converter, top level.
// Instantiates mu8_front, mu8_fifo and mu8_back; depends on mu8_pkg.
//
// Takes one modified UTF-8 byte per cycle on s_axis while the queue has room
// and emits standard UTF-8 bytes on m_axis, one per cycle while m_axis_tready
// is high. Each input byte yields zero to four output transactions; a joined
// surrogate pair yields four, which the back end sends while the front end
// keeps taking input until the record queue (QUEUE_DEPTH records) fills. An
// input byte that ends a string but emits nothing yields one transaction with
// byte_valid low. Records pass through the queue and the back-end register.
module modified_utf8_to_utf8 #(
    parameter int QUEUE_DEPTH = mu8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] run_last
    output logic       m_axis_tlast    // stream_end
);
    import mu8_pkg::*;

    rec_t front_rec, queue_rec;
    logic push, full, pop, empty;

    mu8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .full     (full),
        .push     (push),
        .rec      (front_rec)
    );

    mu8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rec_in  (front_rec),
        .full    (full),
        .pop     (pop),
        .rec_out (queue_rec),
        .empty   (empty)
    );

    mu8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_in     (queue_rec),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .byte_valid (m_axis_tuser[0]),
        .run_last   (m_axis_tuser[1]),
        .stream_end (m_axis_tlast)
    );

    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
        else $error("stream end without run end");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'd0)
        else $error("bare end marker malformed");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser[1] |=> m_axis_tvalid)
        else $error("burst broken before run end");

endmodule

/* hdl/mu8_front.sv */
// Front end: accepts input bytes, tracks character and surrogate state,
// and builds a record per byte that emits or ends a string. Depends on mu8_pkg.
module mu8_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           full,
    output logic           push,
    output mu8_pkg::rec_t  rec
);
    import mu8_pkg::*;

    logic [1:0]  needed_reg, needed_next;
    logic [1:0]  held_reg, held_next;
    logic [7:0]  c0_reg, c0_next;
    logic [7:0]  c1_reg, c1_next;
    logic        hp_reg, hp_next;
    logic [9:0]  hpl_reg, hpl_next;
    logic [15:0] code;
    logic [20:0] cp;
    logic [2:0]  n;
    logic [3:0][7:0] obuf;
    logic        accept;

    assign in_ready = ~full;
    assign accept   = in_valid & ~full;

    always_comb
    begin
        needed_next = needed_reg;
        held_next   = held_reg;
        c0_next     = c0_reg;
        c1_next     = c1_reg;
        hp_next     = hp_reg;
        hpl_next    = hpl_reg;
        n           = 3'd0;
        obuf        = '0;
        code = (needed_reg == LEN_TWO) ? {5'd0, c0_reg[4:0], in_byte[5:0]}
                                       : {c0_reg[3:0], c1_reg[5:0], in_byte[5:0]};
        cp = PLANE_BASE + {1'b0, hpl_reg, code[9:0]};

        if (needed_reg == LEN_IDLE)
        begin
            if (in_byte[7:5] == 3'b110)
            begin
                c0_next     = in_byte;
                held_next   = 2'd1;
                needed_next = LEN_TWO;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                c0_next     = in_byte;
                held_next   = 2'd1;
                needed_next = LEN_THREE;
            end
            else
            begin
                hp_next = 1'b0;
                obuf[0] = in_byte;
                n       = 3'd1;
            end
        end
        else
        begin
            if (held_reg == 2'd1)
                c1_next = in_byte;
            held_next = held_reg + 2'd1;
            if (held_next == needed_reg)
            begin
                held_next   = 2'd0;
                needed_next = LEN_IDLE;
                hp_next     = 1'b0;
                if (code == 16'd0)
                begin
                    hp_next = 1'b0;
                end
                else if (code[15:10] == HIGH_TAG)
                begin
                    hp_next  = 1'b1;
                    hpl_next = code[9:0];
                end
                else if (code[15:10] == LOW_TAG)
                begin
                    if (hp_reg)
                    begin
                        obuf[0] = {5'b11110, cp[20:18]};
                        obuf[1] = {2'b10, cp[17:12]};
                        obuf[2] = {2'b10, cp[11:6]};
                        obuf[3] = {2'b10, cp[5:0]};
                        n       = 3'd4;
                    end
                end
                else
                begin
                    obuf[0] = c0_reg;
                    if (needed_reg == LEN_TWO)
                    begin
                        obuf[1] = in_byte;
                        n       = 3'd2;
                    end
                    else
                    begin
                        obuf[1] = c1_reg;
                        obuf[2] = in_byte;
                        n       = 3'd3;
                    end
                end
            end
        end

        if (in_last)
        begin
            if (held_next == 2'd1)
            begin
                obuf[0] = c0_next;
                n       = 3'd1;
            end
            else if (held_next == 2'd2)
            begin
                obuf[0] = c0_next;
                obuf[1] = c1_next;
                n       = 3'd2;
            end
            held_next   = 2'd0;
            needed_next = LEN_IDLE;
            hp_next     = 1'b0;
            hpl_next    = 10'd0;
        end
    end

    always_comb
    begin
        rec.data     = obuf;
        rec.cnt_m1   = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
        rec.has_byte = (n != 3'd0);
        rec.fin      = in_last;
        push         = accept & ((n != 3'd0) | in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= LEN_IDLE;
            held_reg   <= 2'd0;
            hp_reg     <= 1'b0;
            hpl_reg    <= 10'd0;
        end
        else if (accept)
        begin
            needed_reg <= needed_next;
            held_reg   <= held_next;
            hp_reg     <= hp_next;
            hpl_reg    <= hpl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c0_reg <= c0_next;
            c1_reg <= c1_next;
        end
    end

endmodule

/* hdl/mu8_fifo.sv */
// Short record queue between front and back end.
// Depends on mu8_pkg for the record type.
module mu8_fifo #(
    parameter int DEPTH = mu8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mu8_pkg::rec_t  rec_in,
    output logic           full,
    input  logic           pop,
    output mu8_pkg::rec_t  rec_out,
    output logic           empty
);
    import mu8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rec_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= rec_in;
    end

endmodule

/* hdl/mu8_back.sv */
// Back end: unpacks queued records into one output byte per transaction.
// Depends on mu8_pkg for the record type.
module mu8_back (
    input  logic           clk,
    input  logic           rst_n,
    input  mu8_pkg::rec_t  rec_in,
    input  logic           empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           byte_valid,
    output logic           run_last,
    output logic           stream_end
);
    import mu8_pkg::*;

    rec_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       done;

    assign run_last   = (idx_reg == cur_reg.cnt_m1);
    assign done       = cur_valid_reg & out_ready & run_last;
    assign pop        = (~cur_valid_reg | done) & ~empty;
    assign out_valid  = cur_valid_reg;
    assign out_byte   = cur_reg.data[idx_reg];
    assign byte_valid = cur_reg.has_byte;
    assign stream_end = run_last & cur_reg.fin;

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = rec_in;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (done)
        begin
            cur_valid_next = 1'b0;
        end
        else if (cur_valid_reg && out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

/* test/utf8_conv_check.sv */
`timescale 1ns / 1ps
// Checker for modified_utf8_to_utf8: watches both stream channels, predicts output bytes.
// Depends on mu8_pkg for the length codes and surrogate constants.
module utf8_conv_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         mismatches,
    output int         due,
    output int         checked
);
    import mu8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       str_end;
    } utf8_out_t;

    utf8_out_t  utf8_due_q [$];

    logic [7:0] char_buf [3];
    logic [1:0] need_len;
    logic [1:0] have;
    logic       hi_wait;
    logic [9:0] hi_bits;

    task automatic convert_byte(input logic [7:0] b, input logic last);
        logic [7:0]  emit [4];
        int          n;
        logic [15:0] unit;
        logic [20:0] cp;
        n = 0;
        if (need_len == LEN_IDLE) begin
            if (b[7:5] == 3'b110) begin
                char_buf[0] = b;
                have = 2'd1;
                need_len = LEN_TWO;
            end else if (b[7:4] == 4'b1110) begin
                char_buf[0] = b;
                have = 2'd1;
                need_len = LEN_THREE;
            end else begin
                hi_wait = 1'b0;
                emit[n++] = b;
            end
        end else begin
            if (have < 2'd3)
                char_buf[have] = b;
            have = have + 2'd1;
            if (have >= need_len) begin
                if (need_len == LEN_TWO)
                    unit = {5'd0, char_buf[0][4:0], char_buf[1][5:0]};
                else
                    unit = {char_buf[0][3:0], char_buf[1][5:0], char_buf[2][5:0]};
                if (unit == 16'd0) begin
                    hi_wait = 1'b0;
                end else if (unit[15:10] == HIGH_TAG) begin
                    hi_wait = 1'b1;
                    hi_bits = unit[9:0];
                end else if (unit[15:10] == LOW_TAG) begin
                    if (hi_wait) begin
                        cp = PLANE_BASE + {1'b0, hi_bits, unit[9:0]};
                        emit[n++] = {5'b11110, cp[20:18]};
                        emit[n++] = {2'b10, cp[17:12]};
                        emit[n++] = {2'b10, cp[11:6]};
                        emit[n++] = {2'b10, cp[5:0]};
                    end
                    hi_wait = 1'b0;
                end else begin
                    hi_wait = 1'b0;
                    for (int i = 0; i < int'(need_len); i++)
                        emit[n++] = char_buf[i];
                end
                have = 2'd0;
                need_len = LEN_IDLE;
            end
        end

        if (last) begin
            // truncated tail goes out as collected
            for (int i = 0; i < int'(have) && n < 4; i++)
                emit[n++] = char_buf[i];
            have = 2'd0;
            need_len = LEN_IDLE;
            hi_wait = 1'b0;
            hi_bits = '0;
            if (n == 0)
                utf8_due_q.push_back('{data: 8'h00, valid: 1'b0, run_last: 1'b1,
                                       str_end: 1'b1});
        end

        for (int i = 0; i < n; i++)
            utf8_due_q.push_back('{data: emit[i], valid: 1'b1, run_last: (i == n - 1),
                                   str_end: (i == n - 1) && last});
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        utf8_out_t got;
        utf8_out_t want;
        if (!rst_n) begin
            utf8_due_q.delete();
            need_len = LEN_IDLE;
            have = 2'd0;
            hi_wait = 1'b0;
            hi_bits = '0;
            due = 0;
        end else begin
            if (s_tvalid && s_tready)
                convert_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
                if (utf8_due_q.size() == 0) begin
                    $display("%0t utf8_conv_check: unexpected transaction, got byte %02h ",
                             $time, got.data, "valid %b run_last %b end %b",
                             got.valid, got.run_last, got.str_end);
                    mismatches++;
                end else begin
                    want = utf8_due_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        $display("%0t utf8_conv_check: expected byte %02h valid %b ",
                                 $time, want.data, want.valid,
                                 "run_last %b end %b, got byte %02h valid %b ",
                                 want.run_last, want.str_end, got.data, got.valid,
                                 "run_last %b end %b", got.run_last, got.str_end);
                        mismatches++;
                    end
                end
            end
            due = utf8_due_q.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for modified_utf8_to_utf8: clock, reset, byte stimulus and verdict.
// Depends on the DUT under hdl/ and on utf8_conv_check, which predicts and compares.
module tb_top;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic       m_axis_tlast;

    logic       steady = 1'b0;
    int         sent = 0;
    int         strings = 0;
    int         mismatches;
    int         due;
    int         checked;

    // {last, byte}
    logic [8:0] directed [27] = '{
        9'h041, 9'h000, 9'h080, 9'h0F0,
        9'h0C3, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0C0, 9'h080,
        9'h0E0, 9'h080, 9'h080,
        9'h0ED, 9'h0A0, 9'h080, 9'h0ED, 9'h0B0, 9'h080,
        9'h0ED, 9'h0B0, 9'h080,
        9'h0ED, 9'h0A0, 9'h180,
        9'h1E2
    };

    modified_utf8_to_utf8 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_conv_check i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .m_tlast    (m_axis_tlast),
        .mismatches (mismatches),
        .due        (due),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(99) >= 38);
    end

    // called just after a rising edge; returns at the edge that takes the transaction
    task automatic push_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        sent++;
        if (last)
            strings++;
    endtask

    task automatic push_rand(input logic [7:0] b);
        push_byte(b, $urandom_range(99) < 4);
    endtask

    task automatic push_cont();
        if ($urandom_range(9) == 0)
            push_rand(8'($urandom));
        else
            push_rand(8'h80 | 8'($urandom_range(63)));
    endtask

    task automatic push_random_char();
        int kind;
        kind = $urandom_range(99);
        if (kind < 20) begin
            push_rand(8'($urandom_range(127)));
        end else if (kind < 28) begin
            push_rand(8'($urandom));
        end else if (kind < 43) begin
            push_rand(8'hC0 | 8'($urandom_range(31)));
            push_cont();
        end else if (kind < 58) begin
            push_rand(8'hE0 | 8'($urandom_range(15)));
            push_cont();
            push_cont();
        end else if (kind < 76) begin
            push_rand(8'hED);
            push_rand(8'hA0 | 8'($urandom_range(15)));
            push_cont();
            push_rand(8'hED);
            push_rand(8'hB0 | 8'($urandom_range(15)));
            push_cont();
        end else if (kind < 82) begin
            push_rand(8'hED);
            push_rand(8'hA0 | 8'($urandom_range(15)));
            push_cont();
        end else if (kind < 87) begin
            push_rand(8'hED);
            push_rand(8'hB0 | 8'($urandom_range(15)));
            push_cont();
        end else if (kind < 92) begin
            if ($urandom_range(1)) begin
                push_rand(8'hC0);
                push_rand(8'h80);
            end else begin
                push_rand(8'hE0);
                push_rand(8'h80);
                push_rand(8'h80);
            end
        end else begin
            // string cut off inside a character
            if ($urandom_range(1)) begin
                push_byte(8'hC0 | 8'($urandom_range(31)), 1'b1);
            end else begin
                push_rand(8'hE0 | 8'($urandom_range(15)));
                push_byte(8'h80 | 8'($urandom_range(63)), 1'b1);
            end
        end
    endtask

    initial
    begin : stimulus
        bit drained;
        drained = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            push_byte(directed[k][7:0], directed[k][8]);

        while (sent < 27 + 460)
        begin
            if (!drained && sent >= 200)
            begin
                s_axis_tvalid <= 1'b0;
                @(negedge clk);
                while (due != 0)
                    @(negedge clk);
                @(posedge clk);
                drained = 1'b1;
            end
            steady <= (sent >= 280 && sent < 360);
            push_random_char();
        end
        push_byte(8'h41, 1'b1);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        steady <= 1'b0;

        @(negedge clk);
        while (due != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        $display("tb_top: %0d bytes in %0d strings sent, %0d output transactions compared",
                 sent, strings, checked);
        $display("tb_top: ascii, 2/3-byte chars, surrogate pairs, lone halves, %s",
                 "overlong zeros, cut-off tails, noise");
        if (mismatches == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
